FILE: hw/rtl/pfm_pkg.sv
// ----------------------------------------------------------------------------
// Prime field ALU package
// Field constants, Barrett reduction constant and operation codes shared by
// the arithmetic unit, its sequencer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfm_pkg;

  localparam int unsigned ElemW = 30;
  localparam int unsigned ExpW  = 31;
  localparam int unsigned OpW   = 3;

  localparam logic [ElemW-1:0] MODULUS    = 30'd998244353;
  localparam logic [ExpW-1:0]  INV_EXP    = 31'd998244351;
  localparam logic [ElemW-1:0] FIELD_ONE  = 30'd1;
  localparam logic [31:0]      MOD_X1     = 32'd998244353;
  localparam logic [31:0]      MOD_X2     = 32'd1996488706;
  localparam logic [30:0]      BARRETT_MU = 31'((64'd1 << 60) / 64'd998244353);

  localparam logic [OpW-1:0] OP_ADD = 3'd0;
  localparam logic [OpW-1:0] OP_SUB = 3'd1;
  localparam logic [OpW-1:0] OP_MUL = 3'd2;
  localparam logic [OpW-1:0] OP_POW = 3'd3;
  localparam logic [OpW-1:0] OP_INV = 3'd4;
  localparam logic [OpW-1:0] OP_DIV = 3'd5;

endpackage

`default_nettype wire

FILE: hw/rtl/pfm_if.sv
// ----------------------------------------------------------------------------
// Prime field ALU channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [29:0] operand_a;
  logic [29:0] operand_b;
  logic [30:0] exponent;

  modport source (output valid, operation, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, exponent, output ready);
  modport mon    (input valid, ready, operation, operand_a, operand_b, exponent);
endinterface

interface pfm_rsp_if;
  logic        valid;
  logic        ready;
  logic [29:0] result;
  logic        zero_divisor;

  modport source (output valid, result, zero_divisor, input ready);
  modport sink   (input valid, result, zero_divisor, output ready);
  modport mon    (input valid, ready, result, zero_divisor);
endinterface

`default_nettype wire

FILE: hw/rtl/pfm_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Five-stage pipelined Barrett multiplier modulo 998244353; the ALU keeps one
// product in flight at a time. done pulses when prod holds the reduced result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfm_modmul
  import pfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ElemW-1:0] x,
  input  logic [ElemW-1:0] y,
  output logic             done,
  output logic [ElemW-1:0] prod
);

  logic [4:0]       stage_vld;
  logic [59:0]      p;
  logic [30:0]      q3;
  logic [31:0]      qm;
  logic [31:0]      r;
  logic [59:0]      p_w;
  logic [61:0]      t_w;
  logic [60:0]      qm_w;
  logic [31:0]      r_w;
  logic [ElemW-1:0] prod_w;

  assign p_w  = 60'(x) * 60'(y);
  assign t_w  = p[59:29] * BARRETT_MU;
  assign qm_w = q3 * MODULUS;
  assign r_w  = p[31:0] - qm;

  always_comb begin
    if (r >= MOD_X2) begin
      prod_w = ElemW'(r - MOD_X2);
    end else if (r >= MOD_X1) begin
      prod_w = ElemW'(r - MOD_X1);
    end else begin
      prod_w = ElemW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      stage_vld <= {stage_vld[3:0], start};
    end
    if (start)        p    <= p_w;
    if (stage_vld[0]) q3   <= t_w[61:31];
    if (stage_vld[1]) qm   <= qm_w[31:0];
    if (stage_vld[2]) r    <= r_w;
    if (stage_vld[3]) prod <= prod_w;
  end

  assign done = stage_vld[4];

endmodule

`default_nettype wire

FILE: hw/rtl/prime_field_modular_alu.sv
// ----------------------------------------------------------------------------
// Prime field modular ALU
// Add, subtract, multiply, power, inverse and divide modulo 998244353.
// ----------------------------------------------------------------------------
// Add, subtract, zero divisors and unused codes go from accept to the done state,
// then into the output register. Multiply uses the single Barrett multiplier once;
// power squares and multiplies over the exponent bits from the LSB, inverse raises
// to the power 998244351, and divide multiplies the dividend by that inverse.
// One beat is in work at a time; the next is accepted once the result is
// registered. Synchronous reset returns the sequencer to idle with no result.
`default_nettype none

module prime_field_modular_alu
  import pfm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pfm_req_if.sink       req,
  pfm_rsp_if.source     rsp
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_WAIT, S_DONE} state_t;
  typedef enum logic [1:0] {K_ACC, K_SQR, K_FIN} kind_t;

  state_t           state;
  kind_t            kind;
  logic [OpW-1:0]   op;
  logic [ElemW-1:0] a;
  logic [ElemW-1:0] acc;
  logic [ElemW-1:0] base;
  logic [ExpW-1:0]  e;
  logic [ElemW-1:0] res;
  logic             err;
  logic             mul_start;
  logic             mul_issue;
  logic [ElemW-1:0] mul_x;
  logic [ElemW-1:0] mul_y;
  logic             mul_done;
  logic [ElemW-1:0] mul_prod;
  logic             out_valid;
  logic [ElemW-1:0] out_result;
  logic             out_err;

  logic [ElemW-1:0] ra;
  logic [ElemW-1:0] rb;
  logic [ElemW:0]   sum_w;
  logic [ElemW-1:0] add_w;
  logic [ElemW-1:0] sub_w;

  assign ra    = (req.operand_a >= MODULUS) ? req.operand_a - MODULUS : req.operand_a;
  assign rb    = (req.operand_b >= MODULUS) ? req.operand_b - MODULUS : req.operand_b;
  assign sum_w = {1'b0, ra} + {1'b0, rb};
  assign add_w = (sum_w >= {1'b0, MODULUS}) ? ElemW'(sum_w - {1'b0, MODULUS})
                                            : ElemW'(sum_w);
  assign sub_w = (ra >= rb) ? ra - rb : ElemW'({1'b0, ra} + {1'b0, MODULUS} - {1'b0, rb});

  assign mul_issue = ((state == S_IDLE) && req.valid && (req.operation == OP_MUL))
                  || ((state == S_STEP) && ((e != '0) || (op == OP_DIV)));

  pfm_modmul u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_start <= mul_issue;
      if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op  <= req.operation;
            a   <= ra;
            acc <= FIELD_ONE;
            err <= ((req.operation == OP_INV) && (ra == '0))
                || ((req.operation == OP_DIV) && (rb == '0));
            case (req.operation)
              OP_ADD: begin
                res   <= add_w;
                state <= S_DONE;
              end
              OP_SUB: begin
                res   <= sub_w;
                state <= S_DONE;
              end
              OP_MUL: begin
                mul_x     <= ra;
                mul_y     <= rb;
                kind      <= K_FIN;
                state     <= S_WAIT;
              end
              OP_POW: begin
                base  <= ra;
                e     <= req.exponent;
                state <= S_STEP;
              end
              OP_INV: begin
                if (ra == '0) begin
                  res   <= '0;
                  state <= S_DONE;
                end else begin
                  base  <= ra;
                  e     <= INV_EXP;
                  state <= S_STEP;
                end
              end
              OP_DIV: begin
                if (rb == '0) begin
                  res   <= '0;
                  state <= S_DONE;
                end else begin
                  base  <= rb;
                  e     <= INV_EXP;
                  state <= S_STEP;
                end
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_STEP: begin
          if (e == '0) begin
            if (op == OP_DIV) begin
              mul_x     <= acc;
              mul_y     <= a;
              kind      <= K_FIN;
              state     <= S_WAIT;
            end else begin
              res   <= acc;
              state <= S_DONE;
            end
          end else if (e[0]) begin
            mul_x     <= acc;
            mul_y     <= base;
            kind      <= K_ACC;
            state     <= S_WAIT;
          end else begin
            mul_x     <= base;
            mul_y     <= base;
            kind      <= K_SQR;
            state     <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            case (kind)
              K_ACC: begin
                acc   <= mul_prod;
                e     <= {e[ExpW-1:1], 1'b0};
                state <= S_STEP;
              end
              K_SQR: begin
                base  <= mul_prod;
                e     <= {1'b0, e[ExpW-1:1]};
                state <= S_STEP;
              end
              default: begin
                res   <= mul_prod;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_result <= res;
            out_err    <= err;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result       = out_result;
  assign rsp.zero_divisor = out_err;

endmodule

`default_nettype wire

FILE: hw/rtl/pfm_checker.sv
// ----------------------------------------------------------------------------
// Prime field ALU checker
// Port-level properties of the ALU, bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfm_checker
  import pfm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [ElemW-1:0] rsp_result,
  input logic             rsp_zero_divisor
);

  // A held result beat keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
                                && $stable(rsp_zero_divisor))
    else $error("response changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_result < MODULUS)
    else $error("result is not reduced");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_zero_divisor |-> rsp_result == '0)
    else $error("zero divisor with nonzero result");

  // The unit works on one beat at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind prime_field_modular_alu pfm_checker u_pfm_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result       (rsp.result),
  .rsp_zero_divisor (rsp.zero_divisor)
);

`default_nettype wire
